### rtl/dctsb_pkg.sv
// ----------------------------------------------------------------------------
// dctsb_pkg
// Shared codes and field widths for the character screen shadow buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dctsb_pkg;

    // request codes on req_type
    localparam logic [1:0] REQ_PUT_CHAR = 2'd0;
    localparam logic [1:0] REQ_SET_CUR  = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;
    localparam logic [1:0] REQ_REFRESH  = 2'd3;

    // display command codes on cmd_kind
    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_SET_ADDR = 2'd1;
    localparam logic [1:0] CMD_WRITE    = 2'd2;

    // screen geometry; the out_row/out_col widths are sized for it
    localparam int ROWS = 2;
    localparam int COLS = 16;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned OUT_ROW_W = 1;
    localparam int unsigned OUT_COL_W = 4;

    typedef logic [CHAR_W-1:0] char_t;

endpackage

`default_nettype wire

### rtl/dirty_cell_text_screen_buffer_core.sv
// ----------------------------------------------------------------------------
// dirty_cell_text_screen_buffer_core
// Shadow buffer for a character display with one dirty mark per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a request word is taken at a rising edge with start high
//   and busy low. Put-char stores a byte at the cursor (dirty if changed or a
//   clear is pending) and advances the cursor; set-cursor moves it when the
//   position is on screen; clear homes the cursor, drops all dirty marks and
//   arms a pending clear; refresh emits the display commands.
//   Result channel: each command word is on cmd_kind/out_* for one cycle with
//   strobe high. The receiver cannot stall; words are never held back.
//   last_of_run marks the final word of a refresh.
// Sequencing:
//   set-cursor and clear: done at acceptance. put-char: read, then
//   compare/write on the char memory.
//   refresh: setup, then (if a put-char is pending) per cell a read and an
//   evaluate state, plus a write state for a dirty cell that opens a run
//   (address, then write word), then flush. A word waits in a one-word
//   hold stage until the next is made or the walk ends (so the last can carry
//   last_of_run), then passes the output register; the last word of a
//   refresh is out in the first cycle with busy low.
// Reset: cursor homes, all cells read as zero (per-cell valid flops), dirty
//   marks and pending flags clear. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_cell_text_screen_buffer_core
    import dctsb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           req_type,
    input  wire logic [7:0]           char_code,
    input  wire logic [7:0]           target_row,
    input  wire logic [7:0]           target_col,
    output logic                      strobe,
    output logic [1:0]                cmd_kind,
    output logic [OUT_ROW_W-1:0]      out_row,
    output logic [OUT_COL_W-1:0]      out_col,
    output logic [CHAR_W-1:0]         out_char,
    output logic                      last_of_run
);

    localparam int CELLS = ROWS * COLS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PRD_W = IDX_W + 1;

    // sequencer codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PUT_WR  = 3'd1;
    localparam logic [2:0] ST_REF     = 3'd2;
    localparam logic [2:0] ST_WALK_RD = 3'd3;
    localparam logic [2:0] ST_WALK_EV = 3'd4;
    localparam logic [2:0] ST_WALK_WR = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;

    // ---------------- state ----------------
    logic [2:0]       state_reg,      state_next;
    logic [ROW_W-1:0] cur_row_reg,    cur_row_next;
    logic [COL_W-1:0] cur_col_reg,    cur_col_next;
    logic             clr_pend_reg,   clr_pend_next;
    logic             upd_pend_reg,   upd_pend_next;
    logic [CELLS-1:0] dirty_reg,      dirty_next;
    logic [CELLS-1:0] valid_reg,      valid_next;
    char_t            ch_reg,         ch_next;

    // walker
    logic [ROW_W-1:0] wrow_reg,       wrow_next;
    logic [COL_W-1:0] wcol_reg,       wcol_next;
    logic [IDX_W-1:0] widx_reg,       widx_next;
    logic             need_addr_reg,  need_addr_next;

    // one-word hold stage ahead of the output registers
    logic                 hold_vld_reg,  hold_vld_next;
    logic [1:0]           hold_kind_reg, hold_kind_next;
    logic [OUT_ROW_W-1:0] hold_row_reg,  hold_row_next;
    logic [OUT_COL_W-1:0] hold_col_reg,  hold_col_next;
    char_t                hold_char_reg, hold_char_next;

    // output registers
    logic                 strobe_reg,    strobe_next;
    logic [1:0]           kind_reg,      kind_next;
    logic [OUT_ROW_W-1:0] orow_reg,      orow_next;
    logic [OUT_COL_W-1:0] ocol_reg,      ocol_next;
    char_t                ochar_reg,     ochar_next;
    logic                 last_reg,      last_next;

    // char memory, read data registered
    char_t            mem [CELLS];
    char_t            rdata_reg;
    logic             rd_dirty_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] put_idx;
    logic [PRD_W-1:0] put_prod;
    logic             mem_we;
    char_t            cell_char;

    // generated word this cycle
    logic                 gen_vld;
    logic [1:0]           gen_kind;
    logic [OUT_ROW_W-1:0] gen_row;
    logic [OUT_COL_W-1:0] gen_col;
    char_t                gen_char;
    logic                 walk_adv;
    logic                 accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign put_prod  = PRD_W'(cur_row_reg) * PRD_W'(COLS);
    assign put_idx   = IDX_W'(put_prod + PRD_W'(cur_col_reg));
    assign rd_addr   = (state_reg == ST_IDLE) ? put_idx : widx_reg;
    assign cell_char = rd_valid_reg ? rdata_reg : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[put_idx] <= ch_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        clr_pend_next  = clr_pend_reg;
        upd_pend_next  = upd_pend_reg;
        dirty_next     = dirty_reg;
        valid_next     = valid_reg;
        ch_next        = ch_reg;
        wrow_next      = wrow_reg;
        wcol_next      = wcol_reg;
        widx_next      = widx_reg;
        need_addr_next = need_addr_reg;
        mem_we         = 1'b0;
        gen_vld        = 1'b0;
        gen_kind       = CMD_CLEAR;
        gen_row        = '0;
        gen_col        = '0;
        gen_char       = '0;
        walk_adv       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_PUT_CHAR:
                        begin
                            ch_next    = char_code;
                            state_next = ST_PUT_WR;
                        end
                        REQ_SET_CUR:
                        begin
                            if ((32'(target_row) < ROWS) && (32'(target_col) < COLS))
                            begin
                                cur_row_next = ROW_W'(target_row);
                                cur_col_next = COL_W'(target_col);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cur_row_next  = '0;
                            cur_col_next  = '0;
                            clr_pend_next = 1'b1;
                            dirty_next    = '0;
                        end
                        default:
                        begin
                            state_next = ST_REF;
                        end
                    endcase
                end
            end
            ST_PUT_WR:
            begin
                if ((cell_char != ch_reg) || clr_pend_reg)
                begin
                    mem_we              = 1'b1;
                    valid_next[put_idx] = 1'b1;
                    dirty_next[put_idx] = 1'b1;
                end
                upd_pend_next = 1'b1;
                if (cur_col_reg == COL_W'(COLS - 1))
                begin
                    cur_col_next = '0;
                    cur_row_next = (cur_row_reg == ROW_W'(ROWS - 1)) ? '0
                                                                   : cur_row_reg + 1'b1;
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_REF:
            begin
                if (clr_pend_reg)
                begin
                    gen_vld  = 1'b1;
                    gen_kind = CMD_CLEAR;
                end
                if (upd_pend_reg)
                begin
                    wrow_next      = '0;
                    wcol_next      = '0;
                    widx_next      = '0;
                    need_addr_next = 1'b1;
                    state_next     = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_EV;
            end
            ST_WALK_EV:
            begin
                if (rd_dirty_reg)
                begin
                    if (need_addr_reg)
                    begin
                        gen_vld        = 1'b1;
                        gen_kind       = CMD_SET_ADDR;
                        gen_row        = OUT_ROW_W'(wrow_reg);
                        gen_col        = OUT_COL_W'(wcol_reg);
                        need_addr_next = 1'b0;
                        state_next     = ST_WALK_WR;
                    end
                    else
                    begin
                        gen_vld              = 1'b1;
                        gen_kind             = CMD_WRITE;
                        gen_char             = cell_char;
                        dirty_next[widx_reg] = 1'b0;
                        walk_adv             = 1'b1;
                    end
                end
                else
                begin
                    // a clean cell under a pending clear reads as zero from now on
                    if (clr_pend_reg)
                    begin
                        valid_next[widx_reg] = 1'b0;
                    end
                    need_addr_next = 1'b1;
                    walk_adv       = 1'b1;
                end
            end
            ST_WALK_WR:
            begin
                gen_vld              = 1'b1;
                gen_kind             = CMD_WRITE;
                gen_char             = cell_char;
                dirty_next[widx_reg] = 1'b0;
                walk_adv             = 1'b1;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (walk_adv)
        begin
            widx_next  = widx_reg + 1'b1;
            state_next = ST_WALK_RD;
            if (wcol_reg == COL_W'(COLS - 1))
            begin
                wcol_next      = '0;
                need_addr_next = 1'b1;
                if (wrow_reg == ROW_W'(ROWS - 1))
                begin
                    clr_pend_next = 1'b0;
                    upd_pend_next = 1'b0;
                    state_next    = ST_FIN;
                end
                else
                begin
                    wrow_next = wrow_reg + 1'b1;
                end
            end
            else
            begin
                wcol_next = wcol_reg + 1'b1;
            end
        end
    end

    // ---------------- hold stage and output ----------------
    always_comb
    begin
        hold_vld_next  = hold_vld_reg;
        hold_kind_next = hold_kind_reg;
        hold_row_next  = hold_row_reg;
        hold_col_next  = hold_col_reg;
        hold_char_next = hold_char_reg;
        strobe_next    = 1'b0;
        kind_next      = kind_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        ochar_next     = ochar_reg;
        last_next      = 1'b0;

        priority if (gen_vld)
        begin
            // a newer word exists, so the held one is not the last
            if (hold_vld_reg)
            begin
                strobe_next = 1'b1;
                kind_next   = hold_kind_reg;
                orow_next   = hold_row_reg;
                ocol_next   = hold_col_reg;
                ochar_next  = hold_char_reg;
            end
            hold_vld_next  = 1'b1;
            hold_kind_next = gen_kind;
            hold_row_next  = gen_row;
            hold_col_next  = gen_col;
            hold_char_next = gen_char;
        end
        else if ((state_reg == ST_FIN) && hold_vld_reg)
        begin
            strobe_next   = 1'b1;
            kind_next     = hold_kind_reg;
            orow_next     = hold_row_reg;
            ocol_next     = hold_col_reg;
            ochar_next    = hold_char_reg;
            last_next     = 1'b1;
            hold_vld_next = 1'b0;
        end
        else
        begin
            strobe_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            clr_pend_reg  <= 1'b0;
            upd_pend_reg  <= 1'b0;
            dirty_reg     <= '0;
            valid_reg     <= '0;
            ch_reg        <= '0;
            wrow_reg      <= '0;
            wcol_reg      <= '0;
            widx_reg      <= '0;
            need_addr_reg <= 1'b1;
            hold_vld_reg  <= 1'b0;
            hold_kind_reg <= CMD_CLEAR;
            hold_row_reg  <= '0;
            hold_col_reg  <= '0;
            hold_char_reg <= '0;
            strobe_reg    <= 1'b0;
            kind_reg      <= CMD_CLEAR;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            ochar_reg     <= '0;
            last_reg      <= 1'b0;
            rd_dirty_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            clr_pend_reg  <= clr_pend_next;
            upd_pend_reg  <= upd_pend_next;
            dirty_reg     <= dirty_next;
            valid_reg     <= valid_next;
            ch_reg        <= ch_next;
            wrow_reg      <= wrow_next;
            wcol_reg      <= wcol_next;
            widx_reg      <= widx_next;
            need_addr_reg <= need_addr_next;
            hold_vld_reg  <= hold_vld_next;
            hold_kind_reg <= hold_kind_next;
            hold_row_reg  <= hold_row_next;
            hold_col_reg  <= hold_col_next;
            hold_char_reg <= hold_char_next;
            strobe_reg    <= strobe_next;
            kind_reg      <= kind_next;
            orow_reg      <= orow_next;
            ocol_reg      <= ocol_next;
            ochar_reg     <= ochar_next;
            last_reg      <= last_next;
            rd_dirty_reg  <= dirty_reg[rd_addr];
            rd_valid_reg  <= valid_reg[rd_addr];
        end
    end

    assign strobe      = strobe_reg;
    assign cmd_kind    = kind_reg;
    assign out_row     = orow_reg;
    assign out_col     = ocol_reg;
    assign out_char    = ochar_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire
